// ===== rtl/lsb_first_bit_packer_macros.svh =====
// Assertion macros shared by the bit packer modules.
`ifndef LSB_FIRST_BIT_PACKER_MACROS_SVH
`define LSB_FIRST_BIT_PACKER_MACROS_SVH

// Checks a condition at every clock edge outside reset.
`define LBP_ASSERT(label, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("lsb_first_bit_packer: invariant check failed");

// Checks that a condition in one cycle implies another in the same cycle.
`define LBP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsb_first_bit_packer: implication check failed");

// Checks that a condition in one cycle implies another in the next cycle.
`define LBP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsb_first_bit_packer: next-cycle check failed");

`endif

// ===== rtl/lbp_pkg.sv =====
// Types and constants shared by the bit packer modules.
package lbp_pkg;

  localparam int MAX_FIELD_BITS = 16;
  localparam int VALUE_BITS     = 16;
  localparam int WIDTH_BITS     = 5;
  localparam int BYTE_BITS      = 8;
  localparam int PART_BITS      = BYTE_BITS - 1;
  localparam int CNT_BITS       = 3;
  localparam int ACC_BITS       = VALUE_BITS + PART_BITS;
  localparam int TOTAL_BITS     = 5;
  localparam int WIDTH_LIMIT    = (MAX_FIELD_BITS < VALUE_BITS) ? MAX_FIELD_BITS : VALUE_BITS;
  localparam int JOBQ_DEPTH     = 2;
  localparam int JOBQ_PTR_BITS  = 1;
  localparam int JOBQ_CNT_BITS  = 2;

  localparam logic [1:0] OP_PACK  = 2'd0;
  localparam logic [1:0] OP_FLUSH = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]            op;
    logic [VALUE_BITS-1:0] field_value;
    logic [WIDTH_BITS-1:0] field_width;
  } in_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] packed_byte;
    logic                 last_of_run;
  } out_t;

  // Bytes produced by one input item; byte1 is used only when two is set.
  typedef struct packed {
    logic [BYTE_BITS-1:0] byte0;
    logic [BYTE_BITS-1:0] byte1;
    logic                 two;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ===== rtl/lbp_front.sv =====
// Front end: accepts items, updates the pending bits and forms byte jobs.
`include "lsb_first_bit_packer_macros.svh"

module lbp_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          accept,
  input  lbp_pkg::in_t  item,
  output logic          job_push,
  output lbp_pkg::job_t job
);

  localparam logic [lbp_pkg::WIDTH_BITS-1:0] LIMIT_W = lbp_pkg::WIDTH_BITS'(lbp_pkg::WIDTH_LIMIT);

  logic [lbp_pkg::PART_BITS-1:0]  partial;
  logic [lbp_pkg::PART_BITS-1:0]  partial_next;
  logic [lbp_pkg::CNT_BITS-1:0]   pend;
  logic [lbp_pkg::CNT_BITS-1:0]   pend_next;
  logic [lbp_pkg::WIDTH_BITS-1:0] w_sat;
  logic [lbp_pkg::VALUE_BITS:0]   mask;
  logic [lbp_pkg::VALUE_BITS-1:0] masked;
  logic [lbp_pkg::ACC_BITS-1:0]   acc;
  logic [lbp_pkg::TOTAL_BITS-1:0] total;
  logic [lbp_pkg::PART_BITS-1:0]  pack_partial;

  always_comb begin
    w_sat  = (item.field_width > LIMIT_W) ? LIMIT_W : item.field_width;
    mask   = ~({(lbp_pkg::VALUE_BITS+1){1'b1}} << w_sat);
    masked = item.field_value & mask[lbp_pkg::VALUE_BITS-1:0];
    acc    = {{lbp_pkg::VALUE_BITS{1'b0}}, partial}
           | ({{lbp_pkg::PART_BITS{1'b0}}, masked} << pend);
    total  = {{(lbp_pkg::TOTAL_BITS-lbp_pkg::CNT_BITS){1'b0}}, pend} + w_sat;
    // The number of whole bytes picks which slice of the accumulator stays pending.
    unique case (total[4:3])
      2'd0:    pack_partial = acc[6:0];
      2'd1:    pack_partial = acc[14:8];
      2'd2:    pack_partial = acc[22:16];
      default: pack_partial = acc[6:0];
    endcase
  end

  always_comb begin
    partial_next = partial;
    pend_next    = pend;
    job_push     = 1'b0;
    job.byte0    = acc[7:0];
    job.byte1    = acc[15:8];
    job.two      = total[4];
    unique case (item.op)
      lbp_pkg::OP_PACK: begin
        partial_next = pack_partial;
        pend_next    = total[2:0];
        job_push     = accept && (total[4:3] != 2'd0);
      end
      lbp_pkg::OP_FLUSH: begin
        partial_next = '0;
        pend_next    = '0;
        job.byte0    = {1'b0, partial};
        job.two      = 1'b0;
        job_push     = accept && (pend != '0);
      end
      lbp_pkg::OP_CLEAR: begin
        partial_next = '0;
        pend_next    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial <= '0;
      pend    <= '0;
    end else if (accept) begin
      partial <= partial_next;
      pend    <= pend_next;
    end
  end

  // Bits at or above the pending count are always zero.
  `LBP_ASSERT(a_partial_clean, (partial >> pend) == '0)
  `LBP_ASSERT_NEXT(a_clear_empties, accept && (item.op == lbp_pkg::OP_CLEAR), pend == '0)

endmodule

// ===== rtl/lbp_jobq.sv =====
// Short queue of byte jobs between the front end and the output stage.
`include "lsb_first_bit_packer_macros.svh"

module lbp_jobq (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  lbp_pkg::job_t   wr_job,
  input  logic            pop,
  output lbp_pkg::job_t   rd_job,
  output lbp_pkg::qstat_t stat
);

  lbp_pkg::job_t                   slots [lbp_pkg::JOBQ_DEPTH];
  logic [lbp_pkg::JOBQ_PTR_BITS-1:0] wr_ptr;
  logic [lbp_pkg::JOBQ_PTR_BITS-1:0] rd_ptr;
  logic [lbp_pkg::JOBQ_CNT_BITS-1:0] count;
  logic                              do_push;
  logic                              do_pop;

  assign stat.full  = (count == lbp_pkg::JOBQ_CNT_BITS'(lbp_pkg::JOBQ_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign rd_job     = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  `LBP_ASSERT(a_count_bound, count <= lbp_pkg::JOBQ_CNT_BITS'(lbp_pkg::JOBQ_DEPTH))

endmodule

// ===== rtl/lbp_back.sv =====
// Back end: streams the bytes of each job into the output register.
`include "lsb_first_bit_packer_macros.svh"

module lbp_back (
  input  logic            clk,
  input  logic            rst,
  input  lbp_pkg::job_t   head,
  input  lbp_pkg::qstat_t qstat,
  output logic            q_pop,
  input  logic            pop,
  output logic            empty,
  output lbp_pkg::out_t   result
);

  logic out_valid;
  logic idx;
  logic load;
  logic is_last;

  assign load    = !qstat.empty && (!out_valid || pop);
  assign is_last = idx || !head.two;
  assign q_pop   = load && is_last;
  assign empty   = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= !is_last;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.packed_byte <= idx ? head.byte1 : head.byte0;
      result.last_of_run <= is_last;
    end
  end

  // The second byte of a job is only ever selected for a two-byte job.
  `LBP_ASSERT_IMP(a_second_byte, idx, !qstat.empty && head.two)

endmodule

// ===== rtl/lsb_first_bit_packer.sv =====
// Top level of the LSB-first bit packer.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   item    | in        | push / full        | op, field_value, field_width
//   result  | out       | pop / empty        | packed_byte, last_of_run
//
// An item is taken whenever push is high and full is low; its bytes reach the output
// register one per cycle while the receiver keeps popping.
// Sustained intake is one item per cycle for items giving at most one byte, while the
// receiver keeps popping; for items giving two, the output register sets a lower limit.
// A two-entry job queue decouples intake from output stalls; full rises when it fills.
// Reset is synchronous and clears the pending bits, the queue and the output valid flag.

module lsb_first_bit_packer (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  output logic          full,
  input  lbp_pkg::in_t  item,
  output logic          empty,
  input  logic          pop,
  output lbp_pkg::out_t result
);

  logic            accept;
  logic            job_push;
  logic            q_pop;
  lbp_pkg::job_t   new_job;
  lbp_pkg::job_t   head_job;
  lbp_pkg::qstat_t qstat;

  assign full   = qstat.full;
  assign accept = push && !qstat.full;

  lbp_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (new_job)
  );

  lbp_jobq u_jobq (
    .clk    (clk),
    .rst    (rst),
    .push   (job_push),
    .wr_job (new_job),
    .pop    (q_pop),
    .rd_job (head_job),
    .stat   (qstat)
  );

  lbp_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head_job),
    .qstat  (qstat),
    .q_pop  (q_pop),
    .pop    (pop),
    .empty  (empty),
    .result (result)
  );

endmodule

// ===== tb/lsb_first_bit_packer_check.sv =====
// Checker for the bit packer: predicts output bytes from accepted items and compares them.
module lsb_first_bit_packer_check
  import lbp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  logic full,
  input  in_t  item,
  input  logic empty,
  input  logic pop,
  input  out_t result,
  output int   errors,
  output int   bytes_waiting,
  output int   bytes_checked
);

  logic [PART_BITS-1:0] held_bits;
  logic [CNT_BITS-1:0]  held_count;
  out_t                 byte_queue[$];

  task automatic report(input string msg);
    if (errors < 10) $display("%0t: mismatch: %s", $time, msg);
    errors++;
  endtask

  // Appends the bytes that one item completes to the queue and updates the held bits.
  task automatic predict_bytes(input in_t it);
    logic [31:0] w;
    logic [31:0] acc;
    logic [31:0] total;
    out_t        b;
    case (it.op)
      OP_PACK: begin
        w = (it.field_width > WIDTH_LIMIT) ? WIDTH_LIMIT : it.field_width;
        acc = held_bits | ((it.field_value & ((32'd1 << w) - 32'd1)) << held_count);
        total = held_count + w;
        while (total >= BYTE_BITS) begin
          b.packed_byte = acc[BYTE_BITS-1:0];
          b.last_of_run = (total - BYTE_BITS) < BYTE_BITS;
          byte_queue = {byte_queue, b};
          acc = acc >> BYTE_BITS;
          total = total - BYTE_BITS;
        end
        held_bits = acc[PART_BITS-1:0];
        held_count = total[CNT_BITS-1:0];
      end
      OP_FLUSH: begin
        if (held_count != 0) begin
          b.packed_byte = {1'b0, held_bits};
          b.last_of_run = 1'b1;
          byte_queue = {byte_queue, b};
        end
        held_bits = '0;
        held_count = '0;
      end
      OP_CLEAR: begin
        held_bits = '0;
        held_count = '0;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin : watch
    out_t want;
    if (rst) begin
      held_bits = '0;
      held_count = '0;
      byte_queue.delete();
      errors = 0;
      bytes_checked = 0;
    end else begin
      // Results leave before the item of this edge can add any, so check the pop first.
      if (pop && !empty) begin
        if (byte_queue.size() == 0) begin
          report($sformatf("byte %h last %b with nothing expected",
                           result.packed_byte, result.last_of_run));
        end else begin
          want = byte_queue.pop_front();
          if (result.packed_byte !== want.packed_byte)
            report($sformatf("byte %0d: packed_byte expected %h got %h",
                             bytes_checked, want.packed_byte, result.packed_byte));
          if (result.last_of_run !== want.last_of_run)
            report($sformatf("byte %0d: last_of_run expected %b got %b",
                             bytes_checked, want.last_of_run, result.last_of_run));
        end
        bytes_checked++;
      end
      if (push && !full) predict_bytes(item);
    end
    bytes_waiting = byte_queue.size();
  end

endmodule

// ===== tb/lsb_first_bit_packer_test.sv =====
// Testbench top for the bit packer: stimulus, handshake idling, watchdog and verdict.
module lsb_first_bit_packer_test;
  import lbp_pkg::*;

  localparam logic [1:0] OP_UNUSED   = 2'd3;
  localparam int         RANDOM_ITEMS = 1520;
  localparam int         QUIET_ITEMS  = 150;
  localparam int         STALL_LIMIT  = 2000;

  logic clk = 1'b0;
  logic rst;
  logic push;
  logic full;
  in_t  item;
  logic empty;
  logic pop;
  out_t result;

  int errors;
  int bytes_waiting;
  int bytes_checked;

  int n_pack, n_flush, n_clear, n_unused;
  int push_level, pop_level;
  bit quiet_tail;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  lsb_first_bit_packer dut (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

  lsb_first_bit_packer_check checker_i (
    .clk           (clk),
    .rst           (rst),
    .push          (push),
    .full          (full),
    .item          (item),
    .empty         (empty),
    .pop           (pop),
    .result        (result),
    .errors        (errors),
    .bytes_waiting (bytes_waiting),
    .bytes_checked (bytes_checked)
  );

  // Offers one item and holds it until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic [15:0] value,
                           input logic [4:0] width);
    item <= '{op: op, field_value: value, field_width: width};
    push <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    case (op)
      OP_PACK:  n_pack++;
      OP_FLUSH: n_flush++;
      OP_CLEAR: n_clear++;
      default:  n_unused++;
    endcase
  endtask

  task automatic maybe_idle();
    if (!quiet_tail && $urandom_range(0, 9) < push_level) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Receiver side: stall bursts of random length whose density is redrawn during the run.
  initial begin
    int cyc;
    cyc = 0;
    pop <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (cyc % 100 == 0) pop_level = $urandom_range(0, 3);
      if (!quiet_tail && $urandom_range(0, 9) < pop_level) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 16)) begin
          @(posedge clk);
          cyc++;
        end
      end else begin
        pop <= 1'b1;
        @(posedge clk);
        cyc++;
      end
    end
  end

  // Watchdog: ends the run when no transaction happens for too long.
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) break;
    end
    $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int          counted;
    int          r;
    logic [1:0]  op;
    logic [4:0]  width;
    n_pack = 0;
    n_flush = 0;
    n_clear = 0;
    n_unused = 0;
    quiet_tail = 1'b0;
    push_level = 0;
    rst <= 1'b1;
    push <= 1'b0;
    item <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part: width extremes, saturation, flush and clear corners, unused op.
    send_item(OP_PACK,   16'hFFFF, 5'd0);
    send_item(OP_FLUSH,  16'h0000, 5'd0);
    send_item(OP_PACK,   16'hFFFF, 5'd16);
    send_item(OP_PACK,   16'h0000, 5'd16);
    send_item(OP_PACK,   16'hFFFD, 5'd3);
    send_item(OP_UNUSED, 16'hFFFF, 5'd16);
    send_item(OP_FLUSH,  16'hFFFF, 5'd31);
    send_item(OP_PACK,   16'h0001, 5'd1);
    send_item(OP_PACK,   16'hFF7F, 5'd7);
    send_item(OP_PACK,   16'h001F, 5'd5);
    send_item(OP_PACK,   16'hA5C3, 5'd16);
    send_item(OP_CLEAR,  16'hFFFF, 5'd16);
    send_item(OP_FLUSH,  16'h0000, 5'd0);
    send_item(OP_PACK,   16'h0055, 5'd7);
    send_item(OP_PACK,   16'hFFFF, 5'd16);
    send_item(OP_PACK,   16'h1234, 5'd31);
    send_item(OP_PACK,   16'hFFFF, 5'd17);
    send_item(OP_PACK,   16'h0002, 5'd2);
    send_item(OP_FLUSH,  16'h0000, 5'd0);
    send_item(OP_PACK,   16'h00C3, 5'd8);
    send_item(OP_PACK,   16'h01FF, 5'd9);
    send_item(OP_CLEAR,  16'h0000, 5'd0);
    send_item(OP_UNUSED, 16'h0000, 5'd0);
    send_item(OP_FLUSH,  16'h0000, 5'd0);

    // Random part; ignored items do not count toward the total.
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      if (counted % 50 == 0) push_level = $urandom_range(0, 3);
      quiet_tail = (counted >= RANDOM_ITEMS - QUIET_ITEMS);
      maybe_idle();
      r = $urandom_range(0, 99);
      if (r < 75) op = OP_PACK;
      else if (r < 87) op = OP_FLUSH;
      else if (r < 94) op = OP_CLEAR;
      else op = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) width = 5'($urandom_range(17, 31));
      else width = 5'($urandom_range(0, 16));
      send_item(op, 16'($urandom), width);
      if (op != OP_UNUSED) counted++;
    end
    push <= 1'b0;

    while (bytes_waiting != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d pack, %0d flush, %0d clear and %0d unused-op items;",
             n_pack, n_flush, n_clear, n_unused);
    $display("%0d output bytes compared, %0d mismatches.", bytes_checked, errors);
    if (errors == 0 && bytes_waiting == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/lbp_pkg.sv
rtl/lbp_front.sv
rtl/lbp_jobq.sv
rtl/lbp_back.sv
rtl/lsb_first_bit_packer.sv
tb/lsb_first_bit_packer_check.sv
tb/lsb_first_bit_packer_test.sv
